// ----- src/wsp_pkg.sv -----
// Package for the weighted server picker: field widths, opcodes and sequencer states.
// No dependencies; the interfaces, the top level and the verification files import it.
package wsp_pkg;

    localparam int OPCODE_W    = 2;
    localparam int INDEX_W     = 5;
    localparam int IN_WEIGHT_W = 16;
    localparam int RAND_W      = 31;
    localparam int CFG_W       = 6;
    localparam int RAND_CNT_W  = $clog2(RAND_W);

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD = 2'd0,
        OP_FAIL = 2'd1,
        OP_PICK = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

// ----- src/wsp_req_if.sv -----
// Request channel of the weighted server picker (valid/ready plus request fields).
// Depends on wsp_pkg.
interface wsp_req_if;
    import wsp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [INDEX_W-1:0]     entry_index;
    logic [IN_WEIGHT_W-1:0] entry_weight;
    logic                   entry_is_backup;
    logic [RAND_W-1:0]      random_value;

    modport source (output valid, opcode, entry_index, entry_weight, entry_is_backup,
                    random_value, input ready);
    modport sink   (input valid, opcode, entry_index, entry_weight, entry_is_backup,
                    random_value, output ready);
endinterface

// ----- src/wsp_res_if.sv -----
// Result channel of the weighted server picker (valid/ready plus pick result).
// Depends on wsp_pkg.
interface wsp_res_if;
    import wsp_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] chosen_index;
    logic               found;

    modport source (output valid, chosen_index, found, input ready);
    modport sink   (input valid, chosen_index, found, output ready);
endinterface

// ----- src/wsp_cfg_if.sv -----
// Configuration write channel of the weighted server picker (server_count register).
// Depends on wsp_pkg.
interface wsp_cfg_if;
    import wsp_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] server_count;

    modport source (output valid, server_count, input ready);
    modport sink   (input valid, server_count, output ready);
endinterface

// ----- src/wsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wsp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- src/weighted_server_picker_top.sv -----
// Weighted server picker, top level; uses wsp_pkg, the three channel interfaces and wsp_ram.
// The block keeps a table of TABLE_ENTRIES servers (weight and backup mark in a RAM, failed
// marks in flops cleared by reset). A load or mark-failed request takes effect on its transfer.
// A pick walks the table to sum the weights of healthy primary entries, repeats the walk
// over the backup tier when that sum is zero, reduces random_value modulo the sum in a
// bit-serial restoring divider (one quotient bit per cycle), then walks the table again
// subtracting weights until the remainder falls below the current weight, and finally posts
// the result. With zero or one entry in use a pick goes straight to the result. The RAM read
// port, streamed one entry per cycle, sets the walk length, and one shared subtractor serves
// both divider and walk. The request channel is not ready while a pick is in progress. A
// finished result sits in an output register, so a new request is taken while the previous
// result waits; a pick that completes while the output register is still full holds until it
// drains. Only a pick produces a result. server_count is written through the config channel,
// always ready, and is saturated to TABLE_ENTRIES. There is no clearing pass after reset.
module weighted_server_picker_top #(
    parameter int TABLE_ENTRIES = 32,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsp_req_if.sink   i_req,
    wsp_cfg_if.sink   i_cfg,
    wsp_res_if.source o_res
);
    import wsp_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int SUM_W = WEIGHT_BITS + IDX_W;
    localparam int RAM_W = WEIGHT_BITS + 1;

    // Control state
    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_server_count;
    logic [TABLE_ENTRIES-1:0] r_failed, n_failed;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_rd_vld, n_rd_vld;
    logic                  r_tier, n_tier;
    logic [RAND_CNT_W-1:0] r_bit, n_bit;
    logic                  r_out_valid, n_out_valid;

    // Datapath
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [SUM_W-1:0]      r_rem, n_rem;
    logic [RAND_W-1:0]     r_rnd, n_rnd;
    logic [IDX_W-1:0]      r_pick, n_pick;
    logic                  r_found, n_found;
    logic [INDEX_W-1:0]    r_out_index, n_out_index;
    logic                  r_out_found, n_out_found;

    // Combinational
    logic                  req_xfer;
    logic                  in_range;
    logic [IDX_W-1:0]      wr_addr;
    logic                  ram_wr_en;
    logic                  ram_rd_en;
    logic [RAM_W-1:0]      ram_rd_data;
    logic [WEIGHT_BITS-1:0] rd_weight;
    logic                  rd_backup;
    logic                  eligible;
    logic [CNT_W-1:0]      cnt;
    logic [SUM_W:0]        sub_a, sub_b;
    logic [SUM_W+1:0]      sub_diff;
    logic                  sub_borrow;
    logic [SUM_W-1:0]      acc_sum;

    assign req_xfer  = i_req.valid && i_req.ready;
    assign in_range  = 32'(i_req.entry_index) < 32'(TABLE_ENTRIES);
    assign wr_addr   = IDX_W'(i_req.entry_index);
    assign ram_wr_en = req_xfer && (i_req.opcode == OP_LOAD) && in_range;

    // Entries in use, saturated at the table size
    assign cnt = ({1'b0, r_server_count} > (CFG_W+1)'(TABLE_ENTRIES)) ?
                 CNT_W'(TABLE_ENTRIES) : CNT_W'(r_server_count);

    // Stream one table read per cycle during the sum and walk passes
    assign ram_rd_en = ((r_state == ST_SUM) || (r_state == ST_WALK)) && (r_idx < cnt);

    wsp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_req.entry_is_backup, WEIGHT_BITS'(i_req.entry_weight)}),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    assign rd_weight = ram_rd_data[WEIGHT_BITS-1:0];
    assign rd_backup = ram_rd_data[WEIGHT_BITS];
    assign eligible  = r_rd_vld && !r_failed[r_rd_idx] && (rd_backup == r_tier);

    // Shared subtractor: divider step in ST_DIV, remainder minus weight in ST_WALK
    always_comb begin
        if (r_state == ST_DIV) begin
            sub_a = {r_rem, r_rnd[RAND_W-1]};
            sub_b = {1'b0, r_sum};
        end else begin
            sub_a = {1'b0, r_rem};
            sub_b = (SUM_W+1)'(rd_weight);
        end
    end
    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[SUM_W+1];

    // Weight accumulator for the sum passes
    assign acc_sum = r_sum + SUM_W'(rd_weight);

    assign i_req.ready        = (r_state == ST_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_res.valid        = r_out_valid;
    assign o_res.chosen_index = r_out_index;
    assign o_res.found        = r_out_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_count <= CFG_W'(1);
            r_failed       <= '0;
            r_idx          <= '0;
            r_rd_vld       <= 1'b0;
            r_tier         <= 1'b0;
            r_bit          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_server_count <= i_cfg.server_count;
            end
            r_failed    <= n_failed;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_tier      <= n_tier;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_sum       <= n_sum;
        r_rem       <= n_rem;
        r_rnd       <= n_rnd;
        r_pick      <= n_pick;
        r_found     <= n_found;
        r_out_index <= n_out_index;
        r_out_found <= n_out_found;
    end

    always_comb begin
        n_state     = r_state;
        n_failed    = r_failed;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_tier      = r_tier;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !o_res.ready;
        n_rd_idx    = r_idx[IDX_W-1:0];
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_rnd       = r_rnd;
        n_pick      = r_pick;
        n_found     = r_found;
        n_out_index = r_out_index;
        n_out_found = r_out_found;

        case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    case (i_req.opcode)
                        OP_LOAD: begin
                            if (in_range) begin
                                n_failed[wr_addr] = 1'b0;
                            end
                        end
                        OP_FAIL: begin
                            if (in_range) begin
                                n_failed[wr_addr] = 1'b1;
                            end
                        end
                        OP_PICK: begin
                            n_rnd   = i_req.random_value;
                            n_pick  = '0;
                            n_found = 1'b0;
                            n_idx   = '0;
                            n_sum   = '0;
                            n_tier  = 1'b0;
                            if (cnt == CNT_W'(0)) begin
                                n_state = ST_DONE;
                            end else if (cnt == CNT_W'(1)) begin
                                // single server: entry 0 unless failed, weight ignored
                                n_found = !r_failed[0];
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_SUM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SUM: begin
                if (r_idx < cnt) begin
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (eligible) begin
                    n_sum = acc_sum;
                end
                if ((r_idx == cnt) && r_rd_vld) begin
                    n_rd_vld = 1'b0;
                    n_idx    = '0;
                    if (n_sum != '0) begin
                        n_rem   = '0;
                        n_bit   = RAND_CNT_W'(RAND_W - 1);
                        n_state = ST_DIV;
                    end else if (!r_tier) begin
                        // primary tier empty: sum the backups
                        n_tier = 1'b1;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end

            ST_DIV: begin
                n_rem = sub_borrow ? sub_a[SUM_W-1:0] : sub_diff[SUM_W-1:0];
                n_rnd = {r_rnd[RAND_W-2:0], 1'b0};
                n_bit = r_bit - RAND_CNT_W'(1);
                if (r_bit == '0) begin
                    n_idx   = '0;
                    n_state = ST_WALK;
                end
            end

            ST_WALK: begin
                if (r_idx < cnt) begin
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (eligible) begin
                    if (sub_borrow) begin
                        n_pick   = r_rd_idx;
                        n_found  = 1'b1;
                        n_rd_vld = 1'b0;
                        n_state  = ST_DONE;
                    end else begin
                        n_rem = sub_diff[SUM_W-1:0];
                    end
                end
                if ((r_idx == cnt) && r_rd_vld && !(eligible && sub_borrow)) begin
                    n_rd_vld = 1'b0;
                    n_state  = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_index = r_found ? INDEX_W'(r_pick) : '0;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A new result only ever comes out of the completion state
    a_res_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result posted outside completion state");

    // Divider and walk keep the remainder below the tier sum
    a_rem_below_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_WALK) |-> r_rem < r_sum)
        else $error("remainder not below weight sum");

    // Table walks never run past the entries in use
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM || r_state == ST_WALK) |-> r_idx <= cnt)
        else $error("walk index past server count");

endmodule

// ----- verif/wsp_pick_checker.sv -----
// Checker for the weighted server picker: tracks the server table from observed transfers,
// predicts every pick result and compares it with the result channel.
// Depends on wsp_pkg and the request, config and result interfaces.
module wsp_pick_checker #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wsp_req_if   i_req,
    wsp_cfg_if   i_cfg,
    wsp_res_if   i_res,
    output int   o_mismatches,
    output int   o_picks_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    typedef struct packed {
        logic [INDEX_W-1:0] chosen_index;
        logic               found;
    } t_pick_result;

    // Shadow of the block's table and register.
    logic [CFG_W-1:0]       srv_count;
    logic [IN_WEIGHT_W-1:0] srv_weight [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] srv_backup;
    logic [TABLE_ENTRIES-1:0] srv_failed;

    t_pick_result picks_due [$];

    initial begin
        o_mismatches = 0;
        o_picks_due  = 0;
        srv_backup   = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) srv_weight[i] = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns wsp_pick_checker: %s", $time, msg);
        o_mismatches++;
    endtask

    function automatic longint unsigned tier_total(input int unsigned n, input logic tier);
        longint unsigned total;
        total = 0;
        for (int i = 0; i < n; i++)
            if (!srv_failed[i] && srv_backup[i] == tier) total += srv_weight[i];
        return total;
    endfunction

    function automatic t_pick_result predict_pick(input logic [RAND_W-1:0] rnd);
        t_pick_result    res;
        int unsigned     n;
        logic            use_backup;
        longint unsigned total;
        longint unsigned rem;
        res = '0;
        n = (srv_count > TABLE_ENTRIES) ? TABLE_ENTRIES : srv_count;
        if (n == 0) return res;
        // single server: entry 0 wins whatever its weight, unless failed
        if (n == 1) begin
            res.found = !srv_failed[0];
            return res;
        end
        use_backup = 1'b0;
        total = tier_total(n, 1'b0);
        if (total == 0) begin
            use_backup = 1'b1;
            total = tier_total(n, 1'b1);
            if (total == 0) return res;
        end
        rem = longint'(rnd) % total;
        for (int i = 0; i < n; i++) begin
            if (!srv_failed[i] && srv_backup[i] == use_backup) begin
                if (rem < srv_weight[i]) begin
                    res.chosen_index = INDEX_W'(i);
                    res.found        = 1'b1;
                    return res;
                end
                rem -= srv_weight[i];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pick_result want;
        if (!i_rst_n) begin
            srv_count  = CFG_W'(1);
            srv_failed = '0;
            picks_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) srv_count = i_cfg.server_count;
            if (i_req.valid && i_req.ready) begin
                case (i_req.opcode)
                    OP_LOAD: if (i_req.entry_index < TABLE_ENTRIES) begin
                        srv_weight[i_req.entry_index] = i_req.entry_weight;
                        srv_backup[i_req.entry_index] = i_req.entry_is_backup;
                        srv_failed[i_req.entry_index] = 1'b0;
                    end
                    OP_FAIL: if (i_req.entry_index < TABLE_ENTRIES) begin
                        srv_failed[i_req.entry_index] = 1'b1;
                    end
                    OP_PICK: picks_due.push_back(predict_pick(i_req.random_value));
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (picks_due.size() == 0) begin
                    report_mismatch($sformatf("result with no pick pending (index %0d, found %0b)",
                                              i_res.chosen_index, i_res.found));
                end else begin
                    want = picks_due.pop_front();
                    if (i_res.found !== want.found)
                        report_mismatch($sformatf("found got %0b want %0b",
                                                  i_res.found, want.found));
                    if (i_res.chosen_index !== want.chosen_index)
                        report_mismatch($sformatf("chosen_index got %0d want %0d",
                                                  i_res.chosen_index, want.chosen_index));
                end
            end
        end
        o_picks_due = picks_due.size();
    end

endmodule

// ----- verif/tb_weighted_server_picker_top.sv -----
// Testbench top for the weighted server picker: clock, reset, stimulus and verdict.
// Depends on wsp_pkg, the channel interfaces, weighted_server_picker_top and wsp_pick_checker.
module tb_weighted_server_picker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    localparam int TABLE_ENTRIES   = 32;
    localparam int WEIGHT_BITS     = 16;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 56;
    // wait out the slowest pick after the last result before a register write
    localparam int DRAIN_CYCLES    = 150;
    localparam int LONG_HOLD       = 600;
    localparam int HOLD_PHASE      = 4;
    // slowest legal run is roughly 1300 transfers plus their gaps; keep a wide margin
    localparam int LIMIT_CYCLES    = 1_000_000;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [RAND_W-1:0]   RAND_MAX  = '1;

    logic clk = 1'b0;
    logic rst_n;

    always #(CLK_PERIOD / 2) clk = ~clk;

    wsp_req_if req_if ();
    wsp_cfg_if cfg_if ();
    wsp_res_if res_if ();

    int mismatches;
    int picks_pending;

    // Stimulus bookkeeping only: which entries hold a weight, and their tier,
    // so picks never touch an unwritten entry and outages can target primaries.
    logic [TABLE_ENTRIES-1:0] loaded;
    logic [TABLE_ENTRIES-1:0] backup_shadow;

    // Both sides run without gaps while this is set.
    logic stall_free;
    // Raised by the stimulus, consumed by the result-side process.
    logic start_long_hold;

    weighted_server_picker_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .i_cfg  (cfg_if),
        .o_res  (res_if)
    );

    wsp_pick_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .i_cfg       (cfg_if),
        .i_res       (res_if),
        .o_mismatches(mismatches),
        .o_picks_due (picks_pending)
    );

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int unsigned gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Weights lean on zero, full scale and small values so remainders land on boundaries.
    function automatic logic [IN_WEIGHT_W-1:0] rand_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 25) return '1;
        if (r < 65) return IN_WEIGHT_W'($urandom_range(1, 15));
        return IN_WEIGHT_W'($urandom);
    endfunction

    function automatic logic [RAND_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return RAND_W'($urandom);
        if (r < 90) return RAND_W'($urandom_range(0, 100));
        return RAND_MAX;
    endfunction

    // One request transfer, then an optional idle gap. Valid is left high when
    // there is no gap so that back-to-back transfers never toggle it in one step.
    task automatic offer(input logic [OPCODE_W-1:0]    op,
                         input logic [INDEX_W-1:0]     idx,
                         input logic [IN_WEIGHT_W-1:0] weight,
                         input logic                   backup_mark,
                         input logic [RAND_W-1:0]      rnd);
        int unsigned gap;
        @(negedge clk);
        req_if.opcode          <= op;
        req_if.entry_index     <= idx;
        req_if.entry_weight    <= weight;
        req_if.entry_is_backup <= backup_mark;
        req_if.random_value    <= rnd;
        req_if.valid           <= 1'b1;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        if (op == OP_LOAD) begin
            loaded[idx]        = 1'b1;
            backup_shadow[idx] = backup_mark;
        end
        gap = stall_free ? 0 : gap_len();
        if (gap > 0) begin
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // server_count is only written with the block idle: input quiet, every pick
    // result drained, and a pick's worth of cycles for any trailing load/fail.
    task automatic write_server_count(input logic [CFG_W-1:0] value);
        @(negedge clk);
        req_if.valid <= 1'b0;
        wait (picks_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_if.server_count <= value;
        cfg_if.valid        <= 1'b1;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Result-side ready: random back-pressure, plus one long hold-off on request
    // so the output register fills and the request channel stalls behind it.
    initial begin : result_ready_drive
        int unsigned gap;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (start_long_hold) begin
                start_long_hold = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else begin
                gap = stall_free ? 0 : gap_len();
                if (gap == 0) begin
                    res_if.ready <= 1'b1;
                end else begin
                    res_if.ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb_weighted_server_picker_top: errors");
        $finish;
    end

    initial begin : stimulus
        int unsigned      n_used;
        int               r;
        logic [INDEX_W-1:0] idx;
        logic [CFG_W-1:0] phase_counts [PHASES];

        rst_n                  = 1'b0;
        req_if.valid           = 1'b0;
        req_if.opcode          = OP_LOAD;
        req_if.entry_index     = '0;
        req_if.entry_weight    = '0;
        req_if.entry_is_backup = 1'b0;
        req_if.random_value    = '0;
        cfg_if.valid           = 1'b0;
        cfg_if.server_count    = '0;
        loaded                 = '0;
        backup_shadow          = '0;
        stall_free             = 1'b0;
        start_long_hold        = 1'b0;

        // Settings per random phase: above-table counts (saturate), the table size,
        // zero, one, and a few small counts where the backup tier comes into play.
        phase_counts = '{6'd2, 6'd5, 6'd63, 6'd3, 6'd32, 6'd33,
                         6'd1, 6'd16, 6'd0, 6'd4, 6'd2, 6'd32};
        phase_counts[9] = CFG_W'($urandom_range(2, 12));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed ----
        // Single server at the reset count: entry 0 wins even at weight 0,
        // and loses only once failed.
        offer(OP_LOAD, 5'd0, 16'd0, 1'b0, '0);
        offer(OP_PICK, 5'd0, 16'd0, 1'b0, '0);
        offer(OP_FAIL, 5'd0, 16'd0, 1'b0, '0);
        offer(OP_PICK, 5'd31, '1, 1'b1, RAND_MAX);
        // unused opcode with every field at its top value: no effect, no result
        offer(OP_UNUSED, 5'd31, '1, 1'b1, RAND_MAX);
        // reload revives entry 0
        offer(OP_LOAD, 5'd0, '1, 1'b1, '0);
        offer(OP_PICK, 5'd0, 16'd0, 1'b0, RAND_MAX);

        // Zero servers in use: nothing can be found.
        write_server_count(6'd0);
        offer(OP_PICK, 5'd0, 16'd0, 1'b0, RAND_W'(12345));

        // Two servers, both backup: fallback tier; remainder 65535 skips the full-scale
        // entry exactly and lands on the weight-1 entry.
        write_server_count(6'd2);
        offer(OP_LOAD, 5'd1, 16'd1, 1'b1, '0);
        offer(OP_PICK, 5'd0, 16'd0, 1'b0, RAND_MAX);
        // entry 0 back in the primary tier at full weight
        offer(OP_LOAD, 5'd0, '1, 1'b0, '0);
        offer(OP_PICK, 5'd0, 16'd0, 1'b0, RAND_W'(65534));
        offer(OP_PICK, 5'd0, 16'd0, 1'b0, RAND_W'(65535));
        // primary gone: backup takes over
        offer(OP_FAIL, 5'd0, 16'd0, 1'b0, '0);
        offer(OP_PICK, 5'd0, 16'd0, 1'b0, RAND_W'(7));
        // everything failed
        offer(OP_FAIL, 5'd1, 16'd0, 1'b0, '0);
        offer(OP_PICK, 5'd0, 16'd0, 1'b0, RAND_W'(7));
        // only a zero-weight primary left healthy: both sums zero
        offer(OP_LOAD, 5'd1, 16'd0, 1'b0, '0);
        offer(OP_PICK, 5'd0, 16'd0, 1'b0, RAND_MAX);

        // ---- random phases ----
        for (int p = 0; p < PHASES; p++) begin
            write_server_count(phase_counts[p]);
            n_used = (phase_counts[p] > TABLE_ENTRIES) ? TABLE_ENTRIES : phase_counts[p];
            stall_free = (p % 4 == 1);

            // every entry in use gets a weight before any pick can read it
            for (int i = 0; i < n_used; i++)
                if (!loaded[i])
                    offer(OP_LOAD, INDEX_W'(i), rand_weight(), 1'($urandom_range(0, 2) == 0),
                          rand_value());

            // the long hold-off starts while the sender keeps offering
            if (p == HOLD_PHASE) start_long_hold = 1'b1;

            repeat (ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (n_used > 0 && $urandom_range(0, 9) < 7)
                    idx = INDEX_W'($urandom_range(0, n_used - 1));
                else
                    idx = INDEX_W'($urandom);
                if (r < 38) begin
                    offer(OP_PICK, INDEX_W'($urandom), IN_WEIGHT_W'($urandom), 1'($urandom),
                          rand_value());
                end else if (r < 70) begin
                    offer(OP_LOAD, idx, rand_weight(), 1'($urandom_range(0, 2) == 0),
                          RAND_W'($urandom));
                end else if (r < 88) begin
                    offer(OP_FAIL, idx, IN_WEIGHT_W'($urandom), 1'($urandom),
                          RAND_W'($urandom));
                end else if (r < 93) begin
                    offer(OP_UNUSED, INDEX_W'($urandom), IN_WEIGHT_W'($urandom), 1'($urandom),
                          RAND_W'($urandom));
                end else begin
                    // outage: take down every primary in use, then pick from what is left
                    for (int i = 0; i < n_used; i++)
                        if (!backup_shadow[i])
                            offer(OP_FAIL, INDEX_W'(i), IN_WEIGHT_W'($urandom), 1'($urandom),
                                  RAND_W'($urandom));
                    repeat (3)
                        offer(OP_PICK, INDEX_W'($urandom), IN_WEIGHT_W'($urandom),
                              1'($urandom), rand_value());
                end
            end
        end

        // ---- drain and verdict ----
        @(negedge clk);
        req_if.valid <= 1'b0;
        wait (picks_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0) begin
            $display("tb_weighted_server_picker_top: clean");
        end else begin
            $display("tb_weighted_server_picker_top: errors");
        end
        $finish;
    end

endmodule
